@@ hw/rtl/itgr_pkg.sv @@
// Shared types, constants and tables for the IMU tilt and gyro rate core.
`default_nettype none
package itgr_pkg;

    localparam int CORDIC_STEPS   = 16;
    localparam int BIAS_FRAC_BITS = 4;

    localparam int ANG_FRAC  = 20;
    localparam int IN_SCALE  = 8;
    localparam int TAB_IDX_W = 5;
    localparam int STEP_W    = $clog2(CORDIC_STEPS);
    localparam int CW        = 28;   // CORDIC x/y word
    localparam int ZW        = 32;   // CORDIC angle accumulator
    localparam int ANG_W     = 17;   // rounded angle out of the CORDIC
    localparam int SW        = 24;   // gyro sum width

    localparam int BIAS_W    = 17 + BIAS_FRAC_BITS;
    localparam int DIFF_W    = BIAS_W + 1;
    localparam int PROD_W    = DIFF_W + 11;
    localparam int DIVN_W    = SW + BIAS_FRAC_BITS;
    localparam int DIVC_W    = $clog2(DIVN_W);
    localparam int RATE_HALF = (BIAS_FRAC_BITS == 0) ? 0 : (1 << (BIAS_FRAC_BITS - 1));
    localparam int RATE_W    = 24;

    localparam int SQ_W      = 48;

    localparam logic [1:0] CFG_CALIB_SAMPLES = 2'd0;
    localparam logic [1:0] CFG_GYRO_GAIN     = 2'd1;

    typedef enum logic [1:0] {
        REQ_CALIB = 2'd0,
        REQ_MEAS  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_SUMMED   = 3'd0,
        ST_CAL_DONE = 3'd1,
        ST_MEAS     = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAL_LOAD,
        S_CAL_DIV,
        S_SQ,
        S_SQRT,
        S_ROLL_GO,
        S_ROLL_WAIT,
        S_PITCH_GO,
        S_PITCH_WAIT,
        S_RATE,
        S_FINISH
    } fsm_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ITER,
        C_SCALE,
        C_DONE
    } cor_state_t;

    // atan(2^-i) in units of 2^-20 degree
    function automatic logic [25:0] atan_entry(input logic [TAB_IDX_W-1:0] i);
        logic [25:0] v;
        unique case (i)
            5'd0:    v = 26'd47185920;
            5'd1:    v = 26'd27855475;
            5'd2:    v = 26'd14718068;
            5'd3:    v = 26'd7471121;
            5'd4:    v = 26'd3750058;
            5'd5:    v = 26'd1876857;
            5'd6:    v = 26'd938658;
            5'd7:    v = 26'd469357;
            5'd8:    v = 26'd234682;
            5'd9:    v = 26'd117342;
            5'd10:   v = 26'd58671;
            5'd11:   v = 26'd29335;
            5'd12:   v = 26'd14668;
            5'd13:   v = 26'd7334;
            5'd14:   v = 26'd3667;
            5'd15:   v = 26'd1833;
            5'd16:   v = 26'd917;
            5'd17:   v = 26'd458;
            5'd18:   v = 26'd229;
            5'd19:   v = 26'd115;
            5'd20:   v = 26'd57;
            5'd21:   v = 26'd29;
            5'd22:   v = 26'd14;
            5'd23:   v = 26'd7;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/itgr_cordic.sv @@
// Iterative vectoring CORDIC: atan2(y, x) rounded to hundredths of a degree.
`default_nettype none
module itgr_cordic (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [itgr_pkg::CW-1:0]     y_in,
    input  wire logic signed [itgr_pkg::CW-1:0]     x_in,
    output logic                                    done,
    output logic signed [itgr_pkg::ANG_W-1:0]       angle
);
    import itgr_pkg::*;

    cor_state_t               state_reg, state_next;
    logic [STEP_W-1:0]        step_reg;
    logic signed [CW-1:0]     x_reg, y_reg;
    logic signed [ZW-1:0]     z_reg;
    logic signed [ANG_W-1:0]  angle_reg;

    logic                     special;
    logic signed [CW-1:0]     dx, dy;
    logic signed [ZW-1:0]     tab_val;
    logic signed [39:0]       zl, prod;
    logic [39:0]              pmag, q;

    assign special = (y_in == '0) || (x_in == '0);
    assign dx      = x_reg >>> step_reg;
    assign dy      = y_reg >>> step_reg;
    assign tab_val = $signed(ZW'(atan_entry(TAB_IDX_W'(step_reg))));

    // z * 100 by shifts, then round half away from zero by 2^ANG_FRAC
    assign zl   = {{(40-ZW){z_reg[ZW-1]}}, z_reg};
    assign prod = (zl <<< 6) + (zl <<< 5) + (zl <<< 2);
    assign pmag = prod[39] ? 40'(-prod) : 40'(prod);
    assign q    = (pmag + (40'd1 << (ANG_FRAC - 1))) >> ANG_FRAC;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                    state_next = special ? C_DONE : C_ITER;
            end
            C_ITER:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = C_SCALE;
            end
            C_SCALE: state_next = C_DONE;
            C_DONE:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == C_DONE);
    end

    assign angle = angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    step_reg <= '0;
                    if (y_in == '0)
                        angle_reg <= (x_in < 0) ? ANG_W'(18000) : '0;
                    else if (x_in == '0)
                        angle_reg <= (y_in > 0) ? ANG_W'(9000) : -ANG_W'(9000);
                    else if (x_in < 0)
                    begin
                        // fold into the right half plane
                        z_reg <= (y_in > 0) ? (ZW'(180) <<< ANG_FRAC)
                                            : -(ZW'(180) <<< ANG_FRAC);
                        x_reg <= -x_in;
                        y_reg <= -y_in;
                    end
                    else
                    begin
                        z_reg <= '0;
                        x_reg <= x_in;
                        y_reg <= y_in;
                    end
                end
            end
            C_ITER:
            begin
                step_reg <= step_reg + 1'b1;
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + dy;
                    y_reg <= y_reg - dx;
                    z_reg <= z_reg + tab_val;
                end
                else
                begin
                    x_reg <= x_reg - dy;
                    y_reg <= y_reg + dx;
                    z_reg <= z_reg - tab_val;
                end
            end
            C_SCALE:
            begin
                angle_reg <= prod[39] ? -$signed(ANG_W'(q)) : $signed(ANG_W'(q));
            end
            default:
            begin
            end
        endcase
    end

    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == C_SCALE || $past(start))
        else $error("cordic done without a start or scale step");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_ITER) |-> !done)
        else $error("cordic done while iterating");

    a_special_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_IDLE && start && special) |=> done)
        else $error("axis case did not finish at once");

endmodule
`default_nettype wire

@@ hw/rtl/imu_tilt_and_gyro_rate_core.sv @@
// Top level of the IMU tilt and gyro rate core.
// One beat in gives one beat out. A calibration beat below the sample target adds
// the gyro words to the running sums. The beat that reaches the sample target then
// runs a shared restoring divider, one bit per cycle, for each axis. A measurement
// beat runs a 24-step square root, two CORDIC passes of CORDIC_STEPS steps each
// plus rounding, and three multiply/round steps for the rates. Summing, clear and
// ignored beats go straight to the last state. The input side is held off while
// an item is in work. A finished result sits in the output register and the next
// beat is taken meanwhile. A result waits in the last state while the output
// register still holds an unaccepted beat.
`default_nettype none
module imu_tilt_and_gyro_rate_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  wire logic [95:0]  s_tdata,
    // req_type
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // roll_centideg, pitch_centideg, rate_x_mdps, rate_y_mdps, rate_z_mdps,
    // is_calibrated
    output logic [103:0]      m_tdata,
    // status
    output logic [2:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [9:0]   cfg_data
);
    import itgr_pkg::*;

    fsm_t                     state_reg, state_next;
    logic [7:0]               calib_samples_reg;
    logic [9:0]               gain_reg;
    logic signed [SW-1:0]     sum_reg [3];
    logic signed [BIAS_W-1:0] bias_reg [3];
    logic [7:0]               count_reg;
    logic                     cal_flag_reg;
    logic [1:0]               axis_reg;
    logic                     phase_reg;
    logic [DIVC_W-1:0]        div_cnt_reg;
    logic                     m_tvalid_reg;

    logic signed [15:0]       ax_reg, ay_reg, az_reg;
    logic signed [15:0]       gyro_reg [3];
    logic [DIVN_W-1:0]        div_num_reg;
    logic [7:0]               div_rem_reg;
    logic                     div_neg_reg;
    logic [31:0]              sq_acc_reg;
    logic [SQ_W-1:0]          sqrt_v_reg, sqrt_res_reg, sqrt_bit_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [15:0]       roll_reg;
    logic signed [14:0]       pitch_reg;
    logic signed [RATE_W-1:0] rate_reg [3];
    status_t                  status_reg;
    logic [103:0]             out_data_reg;
    logic [2:0]               out_user_reg;

    logic signed [15:0]       in_ax, in_ay, in_az;
    logic signed [15:0]       in_g [3];
    logic                     in_fire, load_out, cor_start, cor_done;
    logic [7:0]               target;
    logic signed [CW-1:0]     cor_y, cor_x;
    logic signed [ANG_W-1:0]  cor_angle;
    logic                     div_last;
    logic [8:0]               div_shift;
    logic                     div_qbit;
    logic [DIVN_W-1:0]        div_num_next;
    logic signed [DIVN_W-1:0] div_n;
    logic [SQ_W-1:0]          sqrt_try;
    logic signed [DIFF_W-1:0] rate_diff;
    logic [PROD_W-1:0]        rate_mag, rate_q;
    logic signed [RATE_W-1:0] rate_fix;
    logic signed [ANG_W-1:0]  roll_cl, pitch_cl;

    assign in_ax   = s_tdata[15:0];
    assign in_ay   = s_tdata[31:16];
    assign in_az   = s_tdata[47:32];
    assign in_g[0] = s_tdata[63:48];
    assign in_g[1] = s_tdata[79:64];
    assign in_g[2] = s_tdata[95:80];

    assign target    = (calib_samples_reg == 8'd0) ? 8'd1 : calib_samples_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // divider step: one quotient bit per cycle
    assign div_shift    = {div_rem_reg, div_num_reg[DIVN_W-1]};
    assign div_qbit     = (div_shift >= {1'b0, target});
    assign div_num_next = {div_num_reg[DIVN_W-2:0], div_qbit};
    assign div_last     = (div_cnt_reg == DIVC_W'(DIVN_W - 1));
    assign div_n        = $signed({{(DIVN_W-SW){sum_reg[axis_reg][SW-1]}}, sum_reg[axis_reg]})
                          <<< BIAS_FRAC_BITS;

    assign sqrt_try = sqrt_res_reg + sqrt_bit_reg;

    // rate: round half away from zero by 2^F, then saturate
    assign rate_diff = ($signed(DIFF_W'(gyro_reg[axis_reg])) <<< BIAS_FRAC_BITS)
                       - $signed(DIFF_W'(bias_reg[axis_reg]));
    assign rate_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign rate_q    = (rate_mag + PROD_W'(RATE_HALF)) >> BIAS_FRAC_BITS;

    always_comb
    begin
        if (!prod_reg[PROD_W-1] && rate_q > PROD_W'(8388607))
            rate_fix = RATE_W'(8388607);
        else if (prod_reg[PROD_W-1] && rate_q > PROD_W'(8388608))
            rate_fix = -RATE_W'(8388608);
        else if (prod_reg[PROD_W-1])
            rate_fix = -$signed(RATE_W'(rate_q));
        else
            rate_fix = $signed(RATE_W'(rate_q));
    end

    always_comb
    begin
        if (cor_angle > ANG_W'(18000))
            roll_cl = ANG_W'(18000);
        else if (cor_angle < -ANG_W'(18000))
            roll_cl = -ANG_W'(18000);
        else
            roll_cl = cor_angle;
        if (cor_angle > ANG_W'(9000))
            pitch_cl = ANG_W'(9000);
        else if (cor_angle < -ANG_W'(9000))
            pitch_cl = -ANG_W'(9000);
        else
            pitch_cl = cor_angle;
    end

    always_comb
    begin
        if (state_reg == S_ROLL_GO)
        begin
            cor_y = CW'(ay_reg) <<< IN_SCALE;
            cor_x = CW'(az_reg) <<< IN_SCALE;
        end
        else
        begin
            cor_y = -(CW'(ax_reg) <<< IN_SCALE);
            cor_x = $signed(CW'(sqrt_res_reg[23:0]));
        end
    end

    itgr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (cor_y),
        .x_in  (cor_x),
        .done  (cor_done),
        .angle (cor_angle)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority case (s_tuser)
                        REQ_CALIB:
                        begin
                            if (count_reg < target && count_reg + 8'd1 == target)
                                state_next = S_CAL_LOAD;
                            else
                                state_next = S_FINISH;
                        end
                        REQ_MEAS: state_next = S_SQ;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_CAL_LOAD: state_next = S_CAL_DIV;
            S_CAL_DIV:
            begin
                if (div_last)
                    state_next = (axis_reg == 2'd2) ? S_FINISH : S_CAL_LOAD;
            end
            S_SQ:
            begin
                if (phase_reg)
                    state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sqrt_bit_reg == SQ_W'(1))
                    state_next = S_ROLL_GO;
            end
            S_ROLL_GO: state_next = S_ROLL_WAIT;
            S_ROLL_WAIT:
            begin
                if (cor_done)
                    state_next = S_PITCH_GO;
            end
            S_PITCH_GO: state_next = S_PITCH_WAIT;
            S_PITCH_WAIT:
            begin
                if (cor_done)
                    state_next = S_RATE;
            end
            S_RATE:
            begin
                if (phase_reg && axis_reg == 2'd2)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        cor_start = (state_reg == S_ROLL_GO) || (state_reg == S_PITCH_GO);
        load_out  = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            calib_samples_reg <= 8'd60;
            gain_reg          <= 10'd70;
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a]  <= '0;
                bias_reg[a] <= '0;
            end
            count_reg    <= '0;
            cal_flag_reg <= 1'b0;
            axis_reg     <= '0;
            phase_reg    <= 1'b0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CALIB_SAMPLES)
                    calib_samples_reg <= cfg_data[7:0];
                else if (cfg_index == CFG_GYRO_GAIN)
                    gain_reg <= cfg_data;
            end

            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    axis_reg  <= '0;
                    phase_reg <= 1'b0;
                    if (in_fire && s_tuser == REQ_CALIB && count_reg < target)
                    begin
                        for (int a = 0; a < 3; a++)
                            sum_reg[a] <= sum_reg[a] + SW'(in_g[a]);
                        count_reg <= count_reg + 8'd1;
                    end
                    else if (in_fire && s_tuser == REQ_CLEAR)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            sum_reg[a]  <= '0;
                            bias_reg[a] <= '0;
                        end
                        count_reg    <= '0;
                        cal_flag_reg <= 1'b0;
                    end
                end
                S_CAL_LOAD: div_cnt_reg <= '0;
                S_CAL_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_last)
                    begin
                        bias_reg[axis_reg] <= div_neg_reg
                            ? -$signed(BIAS_W'(div_num_next))
                            : $signed(BIAS_W'(div_num_next));
                        axis_reg <= axis_reg + 2'd1;
                        if (axis_reg == 2'd2)
                            cal_flag_reg <= 1'b1;
                    end
                end
                S_SQ:     phase_reg <= ~phase_reg;
                S_RATE:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                        axis_reg <= axis_reg + 2'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_user_reg <= status_reg;
            out_data_reg <= {cal_flag_reg, rate_reg[2], rate_reg[1], rate_reg[0],
                             pitch_reg, roll_reg};
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ax_reg    <= in_ax;
                    ay_reg    <= in_ay;
                    az_reg    <= in_az;
                    for (int a = 0; a < 3; a++)
                    begin
                        gyro_reg[a] <= in_g[a];
                        rate_reg[a] <= '0;
                    end
                    roll_reg  <= '0;
                    pitch_reg <= '0;
                    priority case (s_tuser)
                        REQ_CALIB:
                        begin
                            if (count_reg >= target)
                                status_reg <= ST_IGNORED;
                            else if (count_reg + 8'd1 == target)
                                status_reg <= ST_CAL_DONE;
                            else
                                status_reg <= ST_SUMMED;
                        end
                        REQ_MEAS:  status_reg <= ST_MEAS;
                        REQ_CLEAR: status_reg <= ST_CLEARED;
                        default:   status_reg <= ST_IGNORED;
                    endcase
                end
            end
            S_CAL_LOAD:
            begin
                div_neg_reg <= div_n[DIVN_W-1];
                div_rem_reg <= '0;
                div_num_reg <= (div_n[DIVN_W-1] ? DIVN_W'(-div_n) : DIVN_W'(div_n))
                               + DIVN_W'(target >> 1);
            end
            S_CAL_DIV:
            begin
                div_num_reg <= div_num_next;
                div_rem_reg <= div_qbit ? 8'(div_shift - {1'b0, target}) : div_shift[7:0];
            end
            S_SQ:
            begin
                if (!phase_reg)
                    sq_acc_reg <= 32'(ay_reg * ay_reg);
                else
                begin
                    sqrt_v_reg   <= {SQ_W'(sq_acc_reg + 32'(az_reg * az_reg))} << 16;
                    sqrt_res_reg <= '0;
                    sqrt_bit_reg <= SQ_W'(1) << (SQ_W - 2);
                end
            end
            S_SQRT:
            begin
                if (sqrt_v_reg >= sqrt_try)
                begin
                    sqrt_v_reg   <= sqrt_v_reg - sqrt_try;
                    sqrt_res_reg <= (sqrt_res_reg >> 1) + sqrt_bit_reg;
                end
                else
                    sqrt_res_reg <= sqrt_res_reg >> 1;
                sqrt_bit_reg <= sqrt_bit_reg >> 2;
            end
            S_ROLL_WAIT:
            begin
                if (cor_done)
                    roll_reg <= 16'(roll_cl);
            end
            S_PITCH_WAIT:
            begin
                if (cor_done)
                    pitch_reg <= 15'(pitch_cl);
            end
            S_RATE:
            begin
                if (!phase_reg)
                    prod_reg <= PROD_W'(rate_diff * $signed({1'b0, gain_reg}));
                else
                    rate_reg[axis_reg] <= rate_fix;
            end
            default:
            begin
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("input taken again while an item is in work");

    a_flag_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        cal_flag_reg |-> count_reg != 8'd0)
        else $error("calibrated with no samples summed");

    a_zero_unless_meas: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_MEAS) |-> m_tdata[102:0] == '0)
        else $error("angle or rate nonzero on a non-measurement beat");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd18000
                      && $signed(m_tdata[15:0]) >= -16'sd18000))
        else $error("roll out of range");

endmodule
`default_nettype wire

@@ bench/imu_tilt_and_gyro_rate_core_tb.sv @@
// Self-checking bench for the IMU tilt and gyro rate core: random and directed beats.
module imu_tilt_and_gyro_rate_core_tb;
    import itgr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [23:0] rate_x;
        logic [23:0] rate_y;
        logic [23:0] rate_z;
        logic        calibrated;
    } tilt_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [9:0]   cfg_data;

    imu_tilt_and_gyro_rate_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [7:0]    calib_target_reg;
    logic [9:0]    gain_reg;
    longint        gsum[3];
    int            summed_cnt;
    longint        gbias[3];
    bit            cal_flag;

    tilt_result_t  expected_q[$];
    int            mismatch_cnt;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            quiet_cycles;

    longint atan_deg20[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - res - b;
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle_cdeg(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (y == 0)
            return (x < 0) ? 18000 : 0;
        if (x == 0)
            return (y > 0) ? 9000 : -9000;
        if (x < 0)
        begin
            z = ((y > 0) ? 180 : -180) * (64'sd1 <<< 20);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = floor_shift(x, i);
            dy = floor_shift(y, i);
            if (y > 0)
            begin
                x = x + dy;
                y = y - dx;
                z = z + atan_deg20[i];
            end
            else
            begin
                x = x - dy;
                y = y + dx;
                z = z - atan_deg20[i];
            end
        end
        return round_div(z * 100, 64'sd1 <<< 20);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint gyro_rate(longint g, longint b);
        longint diff;
        diff = g * (64'sd1 <<< BIAS_FRAC_BITS) - b;
        return clip(round_div(diff * longint'(gain_reg), 64'sd1 <<< BIAS_FRAC_BITS),
                    -8388608, 8388607);
    endfunction

    task automatic reset_calibration();
        for (int a = 0; a < 3; a++)
        begin
            gsum[a] = 0;
            gbias[a] = 0;
        end
        summed_cnt = 0;
        cal_flag = 1'b0;
    endtask

    task automatic predict_tilt(input logic [1:0] req, input logic [95:0] data);
        tilt_result_t r;
        longint ax;
        longint ay;
        longint az;
        longint g[3];
        int target;
        ax = longint'($signed(data[15:0]));
        ay = longint'($signed(data[31:16]));
        az = longint'($signed(data[47:32]));
        g[0] = longint'($signed(data[63:48]));
        g[1] = longint'($signed(data[79:64]));
        g[2] = longint'($signed(data[95:80]));
        target = (calib_target_reg == 0) ? 1 : int'(calib_target_reg);
        r = '0;
        r.status = ST_IGNORED;
        if (req == REQ_CALIB)
        begin
            if (summed_cnt < target)
            begin
                for (int a = 0; a < 3; a++)
                    gsum[a] = gsum[a] + g[a];
                summed_cnt++;
                r.status = ST_SUMMED;
                if (summed_cnt == target)
                begin
                    for (int a = 0; a < 3; a++)
                        gbias[a] = round_div(gsum[a] * (64'sd1 <<< BIAS_FRAC_BITS),
                                             longint'(target));
                    cal_flag = 1'b1;
                    r.status = ST_CAL_DONE;
                end
            end
        end
        else if (req == REQ_MEAS)
        begin
            r.status = ST_MEAS;
            r.roll = 16'(clip(vector_angle_cdeg(ay * 256, az * 256), -18000, 18000));
            r.pitch = 15'(clip(vector_angle_cdeg(-ax * 256,
                          int_sqrt((ay * ay + az * az) <<< 16)), -9000, 9000));
            r.rate_x = 24'(gyro_rate(g[0], gbias[0]));
            r.rate_y = 24'(gyro_rate(g[1], gbias[1]));
            r.rate_z = 24'(gyro_rate(g[2], gbias[2]));
        end
        else if (req == REQ_CLEAR)
        begin
            reset_calibration();
            r.status = ST_CLEARED;
        end
        r.calibrated = cal_flag;
        expected_q.push_back(r);
    endtask

    // valid stays high after the beat until the next send or a drain replaces it
    task automatic send_sample(input logic [1:0] req, input logic [95:0] data);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= data;
        predict_tilt(req, data);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_CALIB_SAMPLES)
            calib_target_reg = val[7:0];
        else
            gain_reg = val;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(40)) - 20);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [95:0] rand_sample();
        logic [95:0] d;
        for (int k = 0; k < 6; k++)
            d[k*16 +: 16] = rand_word();
        return d;
    endfunction

    task automatic test_directed();
        logic [95:0] d;
        send_sample(REQ_MEAS, '0);
        send_sample(REQ_MEAS, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        send_sample(REQ_MEAS, {48'h0, 16'h8000, 16'h0000, 16'h0000});
        send_sample(REQ_MEAS, {48'h0, 16'h0000, 16'h7FFF, 16'h0000});
        send_sample(REQ_MEAS, {48'h0, 16'h0000, 16'h8000, 16'h7FFF});
        send_sample(REQ_MEAS, {48'h0, 16'hFFFF, 16'h0001, 16'h8000});
        send_sample(REQ_MEAS, {48'h0, 16'h8000, 16'h8000, 16'h0000});
        send_sample(2'd3, '1);
        send_sample(REQ_CLEAR, '0);
        drain();
        write_register(CFG_CALIB_SAMPLES, 10'd2);
        write_register(CFG_GYRO_GAIN, 10'd1000);
        send_sample(REQ_CALIB, {16'h7FFF, 16'h8000, 16'h0003, 48'h0});
        send_sample(REQ_CALIB, {16'h7FFF, 16'h8000, 16'hFFFA, 48'h0});
        // calibration done: extra sample is ignored
        send_sample(REQ_CALIB, '1);
        send_sample(REQ_MEAS, {16'h8000, 16'h7FFF, 16'h0001, 48'h0});
        send_sample(REQ_MEAS, {16'h7FFF, 16'h8000, 16'hFFFF, 48'h1234_5678_9ABC});
        drain();
        write_register(CFG_GYRO_GAIN, 10'd0);
        send_sample(REQ_MEAS, {16'h7FFF, 16'h8000, 16'h0001, 48'h0});
        drain();
        write_register(CFG_GYRO_GAIN, 10'd1023);
        write_register(CFG_CALIB_SAMPLES, 10'd0);
        send_sample(REQ_CLEAR, '0);
        send_sample(REQ_CALIB, {16'h8000, 16'h8000, 16'h8000, 48'h0});
        d = {16'h7FFF, 16'h7FFF, 16'h7FFF, 48'h0};
        send_sample(REQ_MEAS, d);
        drain();
    endtask

    task automatic test_random(input int count);
        int pick;
        logic [1:0] req;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                drain();
                case ($urandom_range(3))
                    0: write_register(CFG_CALIB_SAMPLES, 10'd1);
                    1: write_register(CFG_CALIB_SAMPLES, 10'd255);
                    default: write_register(CFG_CALIB_SAMPLES, 10'($urandom_range(1, 12)));
                endcase
                case ($urandom_range(3))
                    0: write_register(CFG_GYRO_GAIN, 10'd1);
                    1: write_register(CFG_GYRO_GAIN, 10'd1000);
                    default: write_register(CFG_GYRO_GAIN, 10'($urandom_range(1, 1023)));
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 45)
                req = REQ_CALIB;
            else if (pick < 90)
                req = REQ_MEAS;
            else if (pick < 97)
                req = REQ_CLEAR;
            else
                req = 2'd3;
            send_sample(req, rand_sample());
        end
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        tilt_result_t got;
        tilt_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser;
            {got.calibrated, got.rate_z, got.rate_y, got.rate_x, got.pitch, got.roll} =
                m_tdata[103:0];
            if (expected_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: %h", got);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result mismatch: expected st=%0d roll=%0d pitch=%0d rx=%0d ry=%0d rz=%0d cal=%0d got st=%0d roll=%0d pitch=%0d rx=%0d ry=%0d rz=%0d cal=%0d",
                            exp_r.status, $signed(exp_r.roll), $signed(exp_r.pitch),
                            $signed(exp_r.rate_x), $signed(exp_r.rate_y),
                            $signed(exp_r.rate_z), exp_r.calibrated,
                            got.status, $signed(got.roll), $signed(got.pitch),
                            $signed(got.rate_x), $signed(got.rate_y),
                            $signed(got.rate_z), got.calibrated);
                end
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: count edges with no beat on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_cnt = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        calib_target_reg = 8'd60;
        gain_reg = 10'd70;
        reset_calibration();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(300);
        send_idle_pct = 63;
        test_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 63;
        test_random(300);
        send_idle_pct = 19;
        recv_stall_pct = 19;
        test_random(300);

        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/itgr_pkg.sv
hw/rtl/itgr_cordic.sv
hw/rtl/imu_tilt_and_gyro_rate_core.sv
bench/imu_tilt_and_gyro_rate_core_tb.sv
